// File: rtl/egcd_pkg.sv
package egcd_pkg;

  // Operand width in bits. Inputs are cut to this width and sign extended.
  localparam int WIDTH  = 32;
  // Bits of a positive operand's magnitude. Inputs are never wider than 32 bits.
  localparam int MAG_W  = ((WIDTH < 32) ? WIDTH : 32) - 1;
  // Coefficients are kept modulo 2^COEF_W. Their final values always fit.
  localparam int COEF_W = MAG_W + 1;
  // Counter over the bits of one division.
  localparam int CNT_W  = $clog2(MAG_W);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_POS = 2'd1,
    ST_ORDER   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] first_operand;
    logic signed [31:0] second_operand;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        gcd_value;
    logic signed [31:0] coeff_first;
    logic signed [31:0] coeff_second;
    status_t            status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_UPDATE,
    S_DONE
  } egcd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic mul1;
    logic mul2;
    logic update;
  } egcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic cr_zero;
    logic div_last;
  } egcd_sts_t;

endpackage

// File: rtl/egcd_dp.sv
module egcd_dp
  import egcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  egcd_cmd_t cmd,
  input  in_item_t  in_item,
  output egcd_sts_t sts,
  output out_item_t out_item
);

  logic [MAG_W-1:0]    pr_r, cr_r;
  logic [COEF_W-1:0]   p1_r, p2_r, c1_r, c2_r;
  logic [COEF_W-1:0]   prod_r, n1_r;
  logic [MAG_W-1:0]    rem_r, quo_r;
  logic [CNT_W-1:0]    cnt_r;
  status_t             status_r;

  logic                a_sign, b_sign;
  logic [MAG_W-1:0]    a_mag, b_mag;
  status_t             load_status;

  logic [MAG_W:0]      rem_sh, rem_sub;
  logic                ge;
  logic [MAG_W-1:0]    rem_nxt;

  logic [COEF_W-1:0]   mul_c;
  logic [2*COEF_W-1:0] mul_full;

  // Operand check: the sign bit of the cut operand and a nonzero magnitude.
  always_comb begin
    a_sign = in_item.first_operand[MAG_W];
    b_sign = in_item.second_operand[MAG_W];
    a_mag  = in_item.first_operand[MAG_W-1:0];
    b_mag  = in_item.second_operand[MAG_W-1:0];
    if (a_sign || b_sign || (a_mag == '0) || (b_mag == '0)) begin
      load_status = ST_NOT_POS;
    end else if (a_mag < b_mag) begin
      load_status = ST_ORDER;
    end else begin
      load_status = ST_OK;
    end
  end

  // One bit of restoring division per cycle.
  always_comb begin
    rem_sh  = {rem_r, quo_r[MAG_W-1]};
    rem_sub = rem_sh - {1'b0, cr_r};
    ge      = (rem_sh >= {1'b0, cr_r});
    rem_nxt = ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
  end

  // One shared multiplier, quotient times a coefficient, kept modulo 2^COEF_W.
  assign mul_c    = cmd.mul1 ? c1_r : c2_r;
  assign mul_full = (2*COEF_W)'({1'b0, quo_r}) * (2*COEF_W)'(mul_c);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pr_r     <= a_mag;
      cr_r     <= b_mag;
      p1_r     <= COEF_W'(1);
      p2_r     <= '0;
      c1_r     <= '0;
      c2_r     <= COEF_W'(1);
      status_r <= load_status;
    end
    if (cmd.div_init) begin
      quo_r <= pr_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[MAG_W-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.mul1) begin
      prod_r <= mul_full[COEF_W-1:0];
    end
    if (cmd.mul2) begin
      n1_r   <= p1_r - prod_r;
      prod_r <= mul_full[COEF_W-1:0];
    end
    if (cmd.update) begin
      p1_r <= c1_r;
      c1_r <= n1_r;
      p2_r <= c2_r;
      c2_r <= p2_r - prod_r;
      pr_r <= cr_r;
      cr_r <= rem_r;
    end
  end

  always_comb begin
    sts.err      = (status_r != ST_OK);
    sts.cr_zero  = (cr_r == '0);
    sts.div_last = (cnt_r == CNT_W'(MAG_W - 1));
  end

  always_comb begin
    out_item.status = status_r;
    if (status_r != ST_OK) begin
      out_item.gcd_value    = '0;
      out_item.coeff_first  = '0;
      out_item.coeff_second = '0;
    end else begin
      out_item.gcd_value    = 31'(pr_r);
      out_item.coeff_first  = 32'($signed(p1_r));
      out_item.coeff_second = 32'($signed(p2_r));
    end
  end

  // The remainder of a finished division is below the divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (rem_r < cr_r))
    else $error("remainder not below divisor at row update");

  // An accepted pair either fails a check or starts in order.
  a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> ((pr_r >= cr_r) || (status_r != ST_OK)))
    else $error("operands out of order without error status");

endmodule

// File: rtl/egcd_ctrl.sv
module egcd_ctrl
  import egcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  egcd_sts_t sts,
  output egcd_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  egcd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err) begin
          state_nxt = S_DONE;
        end else if (sts.cr_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_CHECK;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_CHECK:  cmd.div_init = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_MUL1:   cmd.mul1     = 1'b1;
      S_MUL2:   cmd.mul2     = 1'b1;
      S_UPDATE: cmd.update   = 1'b1;
      S_DONE:   out_valid    = 1'b1;
      default:  busy         = 1'b1;
    endcase
  end

  // A result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The unit only goes idle right after delivering a result.
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid))
    else $error("unit went idle without a result");

endmodule

// File: rtl/extended_gcd_unit.sv
// Channel    Ports                         Handshake
// input      start, busy, in_item          taken at a clock edge with start high, busy low
// result     out_valid, out_item           shown for one cycle, taken at the edge ending it
//
// The unit works on one item at a time and is busy from acceptance to the result.
// Each Euclid step is one check, one quotient bit per cycle in the restoring divider,
// two multiplies on the shared multiplier and a row update. Operand errors go from
// the check straight to the result. Reset is synchronous and active low; it
// returns the controller to idle. The receiver takes every result as it is shown.
module extended_gcd_unit
  import egcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // The controller sequences each Euclid step as check, divide, two multiplies
  // and an update; the datapath holds both rows and the shared arithmetic.
  egcd_cmd_t cmd;
  egcd_sts_t sts;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The result fields are read straight from the datapath's row registers,
  // which hold still while the strobe is shown.
  egcd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

// File: sim/extended_gcd_unit_tb.sv
`timescale 1ns / 1ps

module extended_gcd_unit_tb;
  import egcd_pkg::*;

  // Clock period is 10 ns, so the run limit below is counted in cycles.
  localparam int RANDOM_ITEMS = 350;
  // The slowest item needs 44 Euclid steps. The limit allows every item to be that slow,
  // with the longest sender gap, several times over.
  localparam int CYCLE_LIMIT  = 3_000_000;
  // After the last result the bench watches the result port for one worst-case item
  // time, so that a late, spurious result is still caught.
  localparam int DRAIN_CYCLES = 1700;
  // The last items are sent back to back, without sender gaps.
  localparam int QUIET_TAIL   = 30;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Operand pairs that still wait to be offered to the unit.
  in_item_t  pending_items[$];
  // Predicted results, oldest first, one for each item the unit has taken.
  out_item_t expected_results[$];

  int total_items    = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int idle_left      = 0;
  int cycle_count    = 0;

  extended_gcd_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The unit cuts each 32-bit input to WIDTH bits and sign extends it from there.
  // The value is kept as 64 bits so that a negative operand stays negative.
  function automatic logic [63:0] narrow_operand(logic signed [31:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    mask = {64{1'b1}} >> (64 - WIDTH);
    v = {{32{raw[31]}}, raw};
    v = v & mask;
    if (v[WIDTH-1]) begin
      v = v | ~mask;
    end
    return v;
  endfunction

  // Extended Euclid on the rows (1, 0, a) and (0, 1, b). The coefficient columns are
  // kept modulo 2^64; the final coefficients always fit in 32 bits.
  function automatic out_item_t bezout_predict(in_item_t item);
    logic [63:0] a, b, q;
    logic [63:0] prev_x, prev_y, prev_r;
    logic [63:0] cur_x, cur_y, cur_r;
    logic [63:0] nx, ny, nr;
    out_item_t   res;
    a = narrow_operand(item.first_operand);
    b = narrow_operand(item.second_operand);
    res = '0;
    if (a == 64'd0 || a[63] || b == 64'd0 || b[63]) begin
      // The sign test comes first, so a negative first operand never reports order.
      res.status = ST_NOT_POS;
    end else if (a < b) begin
      res.status = ST_ORDER;
    end else begin
      prev_x = 64'd1; prev_y = 64'd0; prev_r = a;
      cur_x  = 64'd0; cur_y  = 64'd1; cur_r  = b;
      while (cur_r != 64'd0) begin
        q  = prev_r / cur_r;
        nx = prev_x - q * cur_x;
        ny = prev_y - q * cur_y;
        nr = prev_r - q * cur_r;
        prev_x = cur_x; prev_y = cur_y; prev_r = cur_r;
        cur_x  = nx;    cur_y  = ny;    cur_r  = nr;
      end
      res.gcd_value    = prev_r[30:0];
      res.coeff_first  = prev_x[31:0];
      res.coeff_second = prev_y[31:0];
      res.status       = ST_OK;
    end
    return res;
  endfunction

  // Most random pairs are well formed (a >= b > 0), since only those run the Euclid
  // loop. Some share a large common factor, some are consecutive Fibonacci numbers,
  // which give the longest chains of quotient steps. The rest are error cases and
  // unfiltered 32-bit noise, which also drive every operand bit both ways.
  function automatic in_item_t random_operands();
    in_item_t        item;
    logic [31:0]     g, lim, a0, b0, neg_val;
    longint unsigned fa, fb, fn;
    int              kind, steps, width_bits;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      fa = 1;
      fb = 1;
      steps = $urandom_range(1, 44);
      repeat (steps) begin
        fn = fa + fb;
        fb = fa;
        fa = fn;
      end
      item.first_operand  = fa[31:0];
      item.second_operand = fb[31:0];
    end else if (kind < 75) begin
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5000) : 32'd1;
      width_bits = $urandom_range(1, 31);
      lim = 32'h7fff_ffff / g;
      if (width_bits < 31 && lim > ((32'd1 << width_bits) - 1)) begin
        lim = (32'd1 << width_bits) - 1;
      end
      a0 = $urandom_range(1, lim);
      b0 = ($urandom_range(0, 15) == 0) ? a0 : $urandom_range(1, a0);
      item.first_operand  = a0 * g;
      item.second_operand = b0 * g;
    end else if (kind < 85) begin
      a0 = $urandom_range(1, 32'h7fff_fffe);
      b0 = $urandom_range(a0 + 1, 32'h7fff_ffff);
      item.first_operand  = a0;
      item.second_operand = b0;
    end else if (kind < 93) begin
      neg_val = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
      item.first_operand  = $urandom;
      item.second_operand = $urandom;
      case ($urandom_range(0, 2))
        0: item.first_operand = neg_val;
        1: item.second_operand = neg_val;
        default: begin
          item.first_operand  = neg_val;
          item.second_operand = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
        end
      endcase
    end else begin
      item.first_operand  = $urandom;
      item.second_operand = $urandom;
    end
    return item;
  endfunction

  task automatic add_pair(logic signed [31:0] a, logic signed [31:0] b);
    in_item_t item;
    item.first_operand  = a;
    item.second_operand = b;
    pending_items.push_back(item);
    total_items++;
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Driver. An item is taken at an edge where start is high and busy is low; the
  // prediction is made from the operands that were on the port at that edge. While an
  // offered item waits, start and the operands stay put. Otherwise the driver either
  // opens a gap with start low or offers the next item. Gaps are often opened just
  // after an item is taken, so they overlap the check, divide and finish phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(bezout_predict(in_item));
        accepted_count++;
      end
      if (start && busy) begin
        // The offered item is still waiting; keep it on the port.
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(1, 12) - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A result is shown for one cycle and taken at the edge that ends it, so it
  // is sampled here at the rising edge and compared field by field with the oldest
  // prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no item outstanding: gcd %0d status %s",
                                  out_item.gcd_value, out_item.status.name()));
      end else begin
        want = expected_results.pop_front();
        if (out_item.gcd_value !== want.gcd_value) begin
          report_mismatch($sformatf("gcd_value %0d, expected %0d",
                                    out_item.gcd_value, want.gcd_value));
        end
        if (out_item.coeff_first !== want.coeff_first) begin
          report_mismatch($sformatf("coeff_first %0d, expected %0d",
                                    out_item.coeff_first, want.coeff_first));
        end
        if (out_item.coeff_second !== want.coeff_second) begin
          report_mismatch($sformatf("coeff_second %0d, expected %0d",
                                    out_item.coeff_second, want.coeff_second));
        end
        if (out_item.status !== want.status) begin
          report_mismatch($sformatf("status %s, expected %s",
                                    out_item.status.name(), want.status.name()));
        end
      end
    end
  end

  // A hung unit ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // Smallest and largest well-formed operands, and equal operands, which take a
    // single step and give x = 0, y = 1.
    add_pair(32'sd1, 32'sd1);
    add_pair(32'sd12, 32'sd12);
    add_pair(32'sh7fff_ffff, 32'sh7fff_ffff);
    add_pair(32'sh7fff_ffff, 32'sd1);
    add_pair(32'sh7fff_ffff, 32'sh7fff_fffe);
    // Consecutive Fibonacci numbers: the longest chain of steps at 32 bits.
    add_pair(32'sd1836311903, 32'sd1134903170);
    add_pair(32'sd240, 32'sd46);
    add_pair(32'sh4000_0000, 32'sh0010_0000);
    add_pair(32'sd1000000007, 32'sd998244353);
    add_pair(32'sd2, 32'sd1);
    // Operands that are zero or negative; this check wins over the order check.
    add_pair(32'sd0, 32'sd5);
    add_pair(32'sd5, 32'sd0);
    add_pair(32'sd0, 32'sd0);
    add_pair(-32'sd1, 32'sd1);
    add_pair(32'sd1, -32'sd1);
    add_pair(32'sh8000_0000, 32'sh8000_0000);
    add_pair(32'sh8000_0000, 32'sd1);
    add_pair(32'sh7fff_ffff, 32'sh8000_0000);
    add_pair(-32'sd5, 32'sd10);
    // First operand below second.
    add_pair(32'sd3, 32'sd7);
    add_pair(32'sd1, 32'sh7fff_ffff);
    add_pair(32'sh7fff_fffe, 32'sh7fff_ffff);
    repeat (RANDOM_ITEMS) begin
      pending_items.push_back(random_operands());
      total_items++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Every item must be taken and every prediction must be met before the drain.
    while (accepted_count < total_items || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: extended_gcd_unit.f
rtl/egcd_pkg.sv
rtl/egcd_dp.sv
rtl/egcd_ctrl.sv
rtl/extended_gcd_unit.sv
sim/extended_gcd_unit_tb.sv
